[rtl/trend_debounced_threshold_alarm_assert.svh]
// Assertion macros used by the checker file.
`ifndef TREND_DEBOUNCED_THRESHOLD_ALARM_ASSERT_SVH
`define TREND_DEBOUNCED_THRESHOLD_ALARM_ASSERT_SVH
`define TDTA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TDTA_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/tdta_pkg.sv]
package tdta_pkg;
  localparam int WindowSize = 16;
  localparam int SampleRate = 10;
  localparam int SampleWidth = 16;
  localparam int PtrWidth = $clog2(WindowSize);
  localparam int FillWidth = $clog2(WindowSize + 1);
  localparam int CntWidth = 8;
  localparam int XWidth = PtrWidth + 1;
  // sums over the window
  localparam int SyWidth = SampleWidth + PtrWidth + 1;
  localparam int SxyWidth = SampleWidth + 2 * PtrWidth + 2;
  // n*Sxy - Sx*Sy and its scaled magnitude
  localparam int NumWidth = SxyWidth + FillWidth + 2;
  localparam int DenWidth = 4 * XWidth + 2;
  localparam int RateWidth = $clog2(SampleRate + 1);
  localparam int CmpWidth = NumWidth + RateWidth + 18 + DenWidth;
  localparam logic [7:0] CounterMax = 8'd255;

  localparam logic [1:0] RegWarning = 2'd0;
  localparam logic [1:0] RegAlarm = 2'd1;
  localparam logic [1:0] RegRequired = 2'd2;
  localparam logic [1:0] RegSlope = 2'd3;

  localparam logic [1:0] LevelNormal = 2'd0;
  localparam logic [1:0] LevelWarning = 2'd1;
  localparam logic [1:0] LevelAlarm = 2'd2;

  typedef logic signed [SampleWidth-1:0] sample_t;

  typedef struct packed {
    logic [1:0] level;
    logic rising_fast;
    logic [CntWidth-1:0] debounce_count;
  } result_t;

  typedef struct packed {
    logic [1:0] index;
    logic [15:0] data;
  } cfg_word_t;
endpackage

[rtl/tdta_if.sv]
interface tdta_sample_if;
  import tdta_pkg::*;
  logic valid;
  logic ready;
  sample_t sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface tdta_result_if;
  logic valid;
  logic ready;
  logic [1:0] level;
  logic rising_fast;
  logic [7:0] debounce_count;
  modport source (output valid, level, rising_fast, debounce_count, input ready);
  modport sink (input valid, level, rising_fast, debounce_count, output ready);
endinterface

interface tdta_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tdta_cell.sv]
// One window slot: on load the newest sample enters the first cell and all
// others take their neighbor's value; on rotate the row circulates.
module tdta_cell (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic rotate,
  input  tdta_pkg::sample_t neighbor,
  input  tdta_pkg::sample_t wrap,
  output tdta_pkg::sample_t value
);
  import tdta_pkg::*;
  sample_t data;
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (load) begin
      data <= neighbor;
    end else if (rotate) begin
      data <= wrap;
    end
  end
  assign value = data;
endmodule

[rtl/tdta_mac.sv]
// Accumulates Sx, Sxx, Sy and Sxy over the oldest-first stream, then forms the
// slope test over a few registered steps.
module tdta_mac (
  input  logic clk,
  input  logic clear,
  input  logic acc_en,
  input  logic [tdta_pkg::XWidth-1:0] x,
  input  tdta_pkg::sample_t y,
  input  logic [tdta_pkg::FillWidth-1:0] n,
  input  logic [15:0] slope_limit,
  input  logic [2:0] phase,
  output logic fast
);
  import tdta_pkg::*;
  logic signed [SyWidth-1:0] sy;
  logic signed [SxyWidth-1:0] sxy;
  logic signed [NumWidth-1:0] n_sxy, sx_sy, num;
  logic [DenWidth-1:0] den, sx, sxx;
  logic [NumWidth-1:0] mag;
  logic [CmpWidth-1:0] lhs, rhs;
  logic signed [XWidth:0] xs;

  assign xs = {1'b0, x};

  always_ff @(posedge clk) begin
    if (clear) begin
      sy <= '0;
      sxy <= '0;
      sx <= '0;
      sxx <= '0;
    end else if (acc_en) begin
      sy <= sy + SyWidth'(y);
      sxy <= sxy + SxyWidth'(y * xs);
      sx <= sx + DenWidth'(x);
      sxx <= sxx + DenWidth'(x * x);
    end
    unique case (phase)
      3'd1: begin
        n_sxy <= NumWidth'(sxy * $signed({1'b0, n}));
        sx_sy <= NumWidth'(sy * $signed({1'b0, sx}));
        den <= DenWidth'(n * sxx - sx * sx);
      end
      3'd2: num <= n_sxy - sx_sy;
      3'd3: begin
        mag <= num[NumWidth-1] ? NumWidth'(-num) : NumWidth'(num);
      end
      3'd4: begin
        lhs <= CmpWidth'(mag * RateWidth'(SampleRate));
        rhs <= CmpWidth'(slope_limit * den);
      end
      default: ;
    endcase
  end
  assign fast = (n >= FillWidth'(2)) && (lhs > rhs);
endmodule

[rtl/trend_debounced_threshold_alarm.sv]
// An accepted sample is followed by the StRotate state, in which the window row
// rotates once through the shared multiply-accumulate, then the StMath phases
// form the slope test, and the result is registered for output.
// A result waits in the output register; the next sample is taken only then.
// Reset (rst, synchronous) clears the window row, fill count, debounce
// counter and restores register defaults.
module trend_debounced_threshold_alarm (
  input logic clk,
  input logic rst,
  tdta_sample_if.sink in_ch,
  tdta_result_if.source out_ch,
  tdta_cfg_if.sink cfg
);
  import tdta_pkg::*;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRotate = 3'd1;
  localparam logic [2:0] StMath = 3'd2;
  localparam logic [2:0] StOut = 3'd3;

  logic [2:0] state;
  logic [PtrWidth:0] step;
  logic [2:0] phase;
  logic [FillWidth-1:0] fill;
  logic [CntWidth-1:0] counter;
  logic signed [15:0] warning_level, alarm_level;
  logic [7:0] required_count;
  logic [15:0] slope_limit;
  sample_t last;
  sample_t cells [WindowSize];
  logic load, rotate, fast, acc_en, clear;
  logic [XWidth-1:0] x;
  logic at_alarm, is_warn, up;
  logic [CntWidth-1:0] counter_next;

  assign in_ch.ready = (state == StIdle);
  assign cfg.ready = 1'b1;
  assign load = in_ch.valid && in_ch.ready;
  assign rotate = (state == StRotate);

  genvar g;
  generate
    for (g = 0; g < WindowSize; g++) begin : g_row
      tdta_cell u_cell (
        .clk(clk), .rst(rst), .load(load), .rotate(rotate),
        .neighbor(g == 0 ? in_ch.sample : cells[(g == 0) ? 0 : g - 1]),
        .wrap(g == 0 ? cells[WindowSize-1] : cells[(g == 0) ? 0 : g - 1]),
        .value(cells[g])
      );
    end
  endgenerate

  // Row is newest-first; rotating sends the last cell back to the front.
  // Oldest valid sample sits at cell fill-1; stream the valid ones oldest first.
  logic [PtrWidth-1:0] tap;
  assign tap = PtrWidth'(fill - 1'b1);
  assign x = XWidth'(step);
  assign acc_en = rotate && (XWidth'(step) < XWidth'(fill));
  assign clear = load;

  // each rotation moves cell fill-1 to fill; read the oldest-so-far at tap
  // after k rotations cell tap holds sample at age (fill-1-k)
  tdta_mac u_mac (
    .clk(clk), .clear(clear), .acc_en(acc_en), .x(x), .y(cells[tap]),
    .n(fill), .slope_limit(slope_limit), .phase(phase), .fast(fast)
  );

  assign at_alarm = last >= alarm_level;
  assign is_warn = last >= warning_level;
  assign up = at_alarm || (is_warn && fast);
  always_comb begin
    counter_next = counter;
    if (up) begin
      if (counter != CounterMax) counter_next = counter + 1'b1;
    end else if (counter != '0) begin
      counter_next = counter - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      step <= '0;
      phase <= '0;
      fill <= '0;
      counter <= '0;
      warning_level <= 16'sd16384;
      alarm_level <= 16'sd24576;
      required_count <= 8'd3;
      slope_limit <= 16'd256;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == 8'(RegWarning)) warning_level <= cfg.data;
        if (cfg.index == 8'(RegAlarm)) alarm_level <= cfg.data;
        if (cfg.index == 8'(RegRequired)) required_count <= cfg.data[7:0];
        if (cfg.index == 8'(RegSlope)) slope_limit <= cfg.data;
      end
      unique case (state)
        StIdle: begin
          if (load) begin
            last <= in_ch.sample;
            if (fill != FillWidth'(WindowSize)) fill <= fill + 1'b1;
            step <= '0;
            state <= StRotate;
          end
        end
        StRotate: begin
          step <= step + 1'b1;
          if (step == (PtrWidth+1)'(WindowSize - 1)) begin
            phase <= 3'd1;
            state <= StMath;
          end
        end
        StMath: begin
          phase <= phase + 1'b1;
          if (phase == 3'd5) begin
            counter <= counter_next;
            out_ch.level <= (counter_next >= required_count) ?
              (at_alarm ? LevelAlarm : (is_warn ? LevelWarning : LevelNormal)) :
              LevelNormal;
            out_ch.rising_fast <= fast;
            out_ch.debounce_count <= counter_next;
            out_ch.valid <= 1'b1;
            phase <= '0;
            state <= StOut;
          end
        end
        StOut: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

[rtl/tdta_checker.sv]
module tdta_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_level,
  input logic out_fast,
  input logic [7:0] out_count
);
  `include "trend_debounced_threshold_alarm_assert.svh"
  `TDTA_ASSERT(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable({out_level, out_fast, out_count}), "result word dropped")
  `TDTA_ASSERT(a_level, clk, rst, out_valid |-> out_level != 2'd3, "bad level code")
  `TDTA_ASSERT(a_busy, clk, rst, in_valid && in_ready |=> !in_ready, "input open after accept")
  `TDTA_ASSERT(a_one, clk, rst, out_valid |-> !in_ready, "new word while result pending")
  `TDTA_ASSERT_NORST(a_rst, clk, rst |=> !out_valid, "result valid out of reset")
endmodule

bind trend_debounced_threshold_alarm tdta_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_level(out_ch.level),
  .out_fast(out_ch.rising_fast), .out_count(out_ch.debounce_count)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import tdta_pkg::*;

  localparam logic [7:0] RegUnknown = 8'd7;

  class alarm_scoreboard;
    logic signed [15:0] warn_lvl, alarm_lvl;
    logic [7:0] req_cnt;
    logic [15:0] slope_lim;
    logic signed [15:0] ring [WindowSize];
    int unsigned wr_ptr, fill;
    logic [7:0] debounce;
    result_t pending [$];
    int mismatches;

    function void clear();
      warn_lvl = 16'sd16384;
      alarm_lvl = 16'sd24576;
      req_cnt = 8'd3;
      slope_lim = 16'd256;
      foreach (ring[i]) ring[i] = '0;
      wr_ptr = 0;
      fill = 0;
      debounce = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] val);
      case (idx)
        8'(RegWarning): warn_lvl = val;
        8'(RegAlarm): alarm_lvl = val;
        8'(RegRequired): req_cnt = val[7:0];
        8'(RegSlope): slope_lim = val;
        default: ;
      endcase
    endfunction

    function bit trend_fast();
      longint n, sx, sy, sxy, sxx, num, den, y;
      int unsigned start;
      n = fill;
      sx = 0; sy = 0; sxy = 0; sxx = 0;
      if (fill < 2) return 0;
      start = (wr_ptr + WindowSize - fill) % WindowSize;
      for (int i = 0; i < fill; i++) begin
        y = ring[(start + i) % WindowSize];
        sx += i;
        sy += y;
        sxy += i * y;
        sxx += i * i;
      end
      num = n * sxy - sx * sy;
      den = n * sxx - sx * sx;
      if (den <= 0) return 0;
      if (num < 0) num = -num;
      return num * SampleRate > longint'(slope_lim) * den;
    endfunction

    function void note_sample(logic signed [15:0] s);
      bit hi_alarm, hi_warn, fast;
      result_t r;
      ring[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % WindowSize;
      if (fill < WindowSize) fill++;
      hi_alarm = s >= alarm_lvl;
      hi_warn = s >= warn_lvl;
      fast = trend_fast();
      if (hi_alarm || (hi_warn && fast)) begin
        if (debounce != CounterMax) debounce++;
      end else if (debounce != 0) begin
        debounce--;
      end
      r.level = LevelNormal;
      if (debounce >= req_cnt)
        r.level = hi_alarm ? LevelAlarm : (hi_warn ? LevelWarning : LevelNormal);
      r.rising_fast = fast;
      r.debounce_count = debounce;
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.level !== exp_r.level || got.rising_fast !== exp_r.rising_fast ||
          got.debounce_count !== exp_r.debounce_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected lvl=%0d fast=%0d cnt=%0d, got lvl=%0d fast=%0d cnt=%0d",
                   exp_r.level, exp_r.rising_fast, exp_r.debounce_count,
                   got.level, got.rising_fast, got.debounce_count);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  tdta_sample_if in_ch();
  tdta_result_if out_ch();
  tdta_cfg_if cfg();

  trend_debounced_threshold_alarm dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.source), .out_ch(out_ch.sink), .cfg(cfg.sink)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  alarm_scoreboard sb = new();
  int idle_pct = 36;
  bit hold_off = 0;
  longint cycles = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.sample = '0;
    out_ch.ready = 0;
    cfg.valid = 0;
    cfg.index = '0;
    cfg.data = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.level, out_ch.rising_fast, out_ch.debounce_count});
    out_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  // valid stays up after an accept until the next word or an idle gap drops it
  task send_sample(logic signed [15:0] s);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task write_cfg(logic [7:0] idx, logic [15:0] val);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg.valid <= 0;
    @(posedge clk);
  endtask

  task drain();
    int guard;
    guard = 0;
    in_ch.valid <= 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (WindowSize + 10) @(posedge clk);
  endtask

  task set_all(logic [15:0] w, logic [15:0] a, logic [7:0] r, logic [15:0] sl);
    drain();
    write_cfg(8'(RegWarning), w);
    write_cfg(8'(RegAlarm), a);
    write_cfg(8'(RegRequired), {8'd0, r});
    write_cfg(8'(RegSlope), sl);
  endtask

  // mostly ramps and level excursions around the thresholds, some noise
  task random_run(int count);
    int k, len, step;
    logic signed [15:0] base;
    k = 0;
    while (k < count) begin
      case ($urandom_range(3))
        0: begin
          len = $urandom_range(4, 24);
          base = 16'($urandom);
          step = $signed($urandom_range(0, 4000)) - 2000;
          for (int i = 0; i < len; i++) begin
            send_sample(16'(int'(base) + i * step));
            k++;
          end
        end
        1: begin
          len = $urandom_range(3, 12);
          base = sb.warn_lvl;
          for (int i = 0; i < len; i++) begin
            send_sample(16'(int'(base) + $signed($urandom_range(0, 2000)) - 1000));
            k++;
          end
        end
        2: begin
          len = $urandom_range(3, 12);
          for (int i = 0; i < len; i++) begin
            send_sample(16'(int'(sb.alarm_lvl) + $signed($urandom_range(0, 600)) - 200));
            k++;
          end
        end
        default: begin
          send_sample(16'($urandom));
          k++;
        end
      endcase
    end
  endtask

  initial begin
    sb.clear();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: short window, extremes, flat and steep traces
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    for (int i = 0; i < 6; i++) send_sample(16'sd30000);
    for (int i = 0; i < 4; i++) send_sample(16'(i * 3000 + 10000));
    drain();
    write_cfg(RegUnknown, 16'hffff);
    // warning above alarm, required count zero, slope limits at extremes
    set_all(16'sh7fff, 16'sh8000, 8'd0, 16'd0);
    for (int i = 0; i < 4; i++) send_sample(16'(i * 17));
    set_all(16'sh0000, 16'sh7fff, 8'd255, 16'hffff);
    for (int i = 0; i < 4; i++) send_sample(16'sh5555 ^ 16'(i));

    // long stretch with no idling; counter up to saturation
    set_all(16'sh8000, 16'sh8000, 8'd1, 16'd256);
    idle_pct = 0;
    for (int i = 0; i < 270; i++) send_sample(16'($urandom));
    idle_pct = 36;

    set_all(16'sd16384, 16'sd24576, 8'd3, 16'd256);
    random_run(350);

    // receiver holds off while samples keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_run(30);
    join

    set_all(16'($urandom), 16'($urandom), 8'($urandom_range(1, 8)),
            16'($urandom_range(0, 3000)));
    random_run(350);
    set_all(-16'sd1000, 16'sd2000, 8'd2, 16'd50);
    random_run(350);
    set_all(16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    random_run(300);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/tdta_pkg.sv
rtl/tdta_if.sv
rtl/tdta_cell.sv
rtl/tdta_mac.sv
rtl/trend_debounced_threshold_alarm.sv
rtl/tdta_checker.sv
verif/tb_top.sv
